FILE: design/llh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llh_pkg
// Shared widths, types and the fixed lux threshold table of the light-level
// hysteresis block.
// ----------------------------------------------------------------------------
package llh_pkg;

   localparam int LUX_W     = 16;
   localparam int COUNT_W   = 16;
   localparam int LEVEL_W   = 3;
   localparam int REP_W     = 13;
   localparam int TABLE_ROWS = 8;

   // lux = count * 10 / 12 = count * 5 / 6, done as a multiply by a rounded-up
   // reciprocal and a shift; the error stays far below one sixth for 16-bit counts
   localparam int RECIP_W   = 20;
   localparam int LUX_SHIFT = 20;
   localparam logic [RECIP_W-1:0] LUX_RECIP = 20'd873814;
   localparam int PROD_W    = COUNT_W + RECIP_W;

   // per-level thresholds and representative lux
   localparam logic [LUX_W-1:0] THR_DOWN [TABLE_ROWS] = '{
      16'd0, 16'd5, 16'd34, 16'd116, 16'd340, 16'd1160, 16'd3400, 16'd5000
   };
   localparam logic [LUX_W-1:0] THR_UP [TABLE_ROWS] = '{
      16'd10, 16'd48, 16'd188, 16'd520, 16'd1880, 16'd4500, 16'd6000, 16'd65528
   };
   localparam logic [REP_W-1:0] REP_LUX [TABLE_ROWS] = '{
      13'd5, 13'd22, 13'd75, 13'd220, 13'd800, 13'd2800, 13'd4800, 13'd6000
   };

   // comparator result
   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_result_type;

endpackage
`default_nettype wire

FILE: design/llh_cmp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llh_cmp
// Shared magnitude comparator: reports a < b and a == b on lux-wide operands.
// ----------------------------------------------------------------------------
module llh_cmp (
   input  wire logic [llh_pkg::LUX_W-1:0] a,
   input  wire logic [llh_pkg::LUX_W-1:0] b,
   output llh_pkg::cmp_result_type        res
);
   import llh_pkg::*;

   // one subtract-style compare
   always_comb begin
      res.lt = (a < b);
      res.eq = (a == b);
   end

endmodule
`default_nettype wire

FILE: design/lux_level_hysteresis_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lux_level_hysteresis_top
// Converts a raw light count to lux and picks a brightness level with
// hysteresis over a fixed eight-row threshold table.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one raw 16-bit count per transfer. rsp_* returns one result
//   per request: lux, the chosen level and that level's representative lux.
//   The block works on one item at a time; req_tready is high only while the
//   sequencer is idle.
// Sequence:
//   After acceptance the count is scaled, then compared with the stored lux;
//   unless the two are equal, the level then walks one table row per cycle
//   through the shared comparator, and last the result is loaded.
// Reset:
//   Synchronous, active high. Stored level and stored lux clear to zero and
//   no result is pending.
// Stall:
//   A result waits in the output register while rsp_tready is low; the next
//   result is held in the sequencer until the register frees, and no new
//   request is taken meanwhile.
// ----------------------------------------------------------------------------
module lux_level_hysteresis_top #(
   parameter int NUM_LEVELS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: [15:0] raw_count
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   // rsp_tdata: [15:0] lux_value, [18:16] level, [31:19] representative_lux
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata
);
   import llh_pkg::*;

   localparam int LEVELS_EFF = (NUM_LEVELS > TABLE_ROWS) ? TABLE_ROWS :
                               ((NUM_LEVELS < 2) ? 2 : NUM_LEVELS);
   localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(LEVELS_EFF - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_CMP  = 5'b00100,
      S_WALK = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LUX_W-1:0]     lux_ff, lux_in;
   logic [LEVEL_W-1:0]   lvl_ff, lvl_in;
   logic                 up_ff, up_in;
   logic                 chg_ff, chg_in;
   logic [LEVEL_W-1:0]   last_level_ff, last_level_in;
   logic [LUX_W-1:0]     last_lux_ff, last_lux_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_data_ff, rsp_data_in;

   logic [PROD_W-1:0]    prod;
   logic [LUX_W-1:0]     cmp_b;
   cmp_result_type       cmp_res;
   logic                 fin_go;

   // scale: count times reciprocal, kept high bits
   assign prod = PROD_W'(count_ff) * PROD_W'(LUX_RECIP);

   // second operand of the shared comparator
   always_comb begin
      if (state_ff == S_CMP) begin
         cmp_b = last_lux_ff;
      end else if (up_ff) begin
         cmp_b = THR_UP[lvl_ff];
      end else begin
         cmp_b = THR_DOWN[lvl_ff];
      end
   end

   llh_cmp u_cmp (
      .a   (lux_ff),
      .b   (cmp_b),
      .res (cmp_res)
   );

   assign fin_go = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      lux_in        = lux_ff;
      lvl_in        = lvl_ff;
      up_in         = up_ff;
      chg_in        = chg_ff;
      last_level_in = last_level_ff;
      last_lux_in   = last_lux_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               count_in = req_tdata;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            lux_in   = prod[LUX_SHIFT +: LUX_W];
            lvl_in   = (last_level_ff > TOP_LEVEL) ? TOP_LEVEL : last_level_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            up_in  = !cmp_res.lt && !cmp_res.eq;
            chg_in = !cmp_res.eq;
            if (cmp_res.eq) begin
               state_in = S_FIN;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // one table row per cycle
            if (up_ff) begin
               if ((lvl_ff < TOP_LEVEL) && !cmp_res.lt) begin
                  lvl_in = lvl_ff + LEVEL_W'(1);
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               if ((lvl_ff != '0) && cmp_res.lt) begin
                  lvl_in = lvl_ff - LEVEL_W'(1);
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (fin_go) begin
               rsp_data_in  = {REP_LUX[lvl_ff], lvl_ff, lux_ff};
               rsp_valid_in = 1'b1;
               if (chg_ff) begin
                  last_level_in = lvl_ff;
                  last_lux_in   = lux_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_level_ff <= '0;
         last_lux_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_level_ff <= last_level_in;
         last_lux_ff   <= last_lux_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      lux_ff      <= lux_in;
      lvl_ff      <= lvl_in;
      up_ff       <= up_in;
      chg_ff      <= chg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // an accepted count always goes to the scaling step
   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_MUL))
      else $error("accepted transfer did not start scaling");

   // the upward walk never lowers the level
   a_walk_up_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && up_ff) |=> (lvl_ff >= $past(lvl_ff)))
      else $error("upward walk lowered the level");

   // stored state matches the result just loaded
   a_state_matches_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && fin_go) |=>
         (last_lux_ff == rsp_tdata[15:0] && last_level_ff == rsp_tdata[18:16]))
      else $error("stored lux or level differs from the result");

   // stored level stays within the levels in use
   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> (last_level_ff <= TOP_LEVEL && lvl_ff <= TOP_LEVEL))
      else $error("level above the top level");
`endif

endmodule
`default_nettype wire
